// File: hdl/matrix_multiply_engine_macros.svh
// Assertion macros shared by the matrix multiply engine.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mme_pkg.sv
// Shared types, constants and helpers for the matrix multiply engine.
// No dependencies.
package mme_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned MUL_W       = 2 * ELEM_W;
  localparam int unsigned PROD_W      = 35;
  localparam int unsigned POS_W       = 3;

  localparam logic OP_LOAD_A = 1'b0;
  localparam logic OP_LOAD_B = 1'b1;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } mme_reg_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mme_mac_ctl_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hdl/matrix_multiply_engine.sv
// Matrix multiply engine top level: configuration, load counters, sequencer, result register.
// Depends on mme_pkg, mme_mem, mme_mac and matrix_multiply_engine_macros.svh.
// Loads of A or B take one word per cycle while in_stall_o is low. The load that completes B
// starts the product: the elements are computed in turn by the single multiply-accumulate unit
// fed by one read port per store, and no input word is taken until the last result has been
// placed in the output register. A size mismatch places its single error word in the output
// register at the edge after the completing load, or later if that register is still held by
// a stalled word. A result may wait in the output register while the next element is computed.
`include "matrix_multiply_engine_macros.svh"

module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PROD_W-1:0] product_value_o,
  output logic [POS_W-1:0]         out_row_o,
  output logic [POS_W-1:0]         out_col_o,
  output logic                     last_result_o,
  output logic                     size_error_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_WAIT,
    S_EMIT,
    S_ERR
  } state_e;

  state_e                   state_q;
  logic [DIM_W-1:0]         rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [DIM_W-1:0]         ra, ca, rb, cb;
  logic [CW-1:0]            size_a, size_b;
  logic [CW-1:0]            cnt_a_q, cnt_b_q;
  logic [CW-1:0]            idx_a, idx_b, nxt_a, nxt_b;
  logic [DW-1:0]            i_q, j_q, k_q;
  logic                     in_acc, load_a, load_b, b_full;
  logic                     row_end, col_end, k_end;
  logic                     out_free, out_load;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic [ELEM_W-1:0]        rdata_a, rdata_b;
  mme_mac_ctl_t             mac_ctl;
  logic signed [PROD_W-1:0] acc;
  logic                     mac_done;

  logic                     out_valid_q, last_q, err_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [POS_W-1:0]         row_q, col_q;

  assign ra = eff_dim(rows_a_q, DIM_W'(MAX_DIM));
  assign ca = eff_dim(cols_a_q, DIM_W'(MAX_DIM));
  assign rb = eff_dim(rows_b_q, DIM_W'(MAX_DIM));
  assign cb = eff_dim(cols_b_q, DIM_W'(MAX_DIM));

  assign size_a = CW'(ra) * CW'(ca);
  assign size_b = CW'(rb) * CW'(cb);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_a     = in_acc && (operation_i == OP_LOAD_A);
  assign load_b     = in_acc && (operation_i == OP_LOAD_B);

  assign idx_a  = (cnt_a_q >= size_a) ? '0 : cnt_a_q;
  assign idx_b  = (cnt_b_q >= size_b) ? '0 : cnt_b_q;
  assign nxt_a  = idx_a + CW'(1);
  assign nxt_b  = idx_b + CW'(1);
  assign b_full = (nxt_b >= size_b);

  assign k_end   = (DIM_W'(k_q) == ca - DIM_W'(1));
  assign col_end = (DIM_W'(j_q) == cb - DIM_W'(1));
  assign row_end = (DIM_W'(i_q) == ra - DIM_W'(1));

  assign raddr_a = AW'(CW'(i_q) * CW'(ca) + CW'(k_q));
  assign raddr_b = AW'(CW'(k_q) * CW'(cb) + CW'(j_q));

  assign mac_ctl.valid = (state_q == S_MAC);
  assign mac_ctl.first = (k_q == '0);
  assign mac_ctl.last  = k_end;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_ERR));

  mme_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (ELEM_W)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (load_a),
    .waddr_i (idx_a[AW-1:0]),
    .wdata_i (element_value_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mme_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (ELEM_W)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (load_b),
    .waddr_i (idx_b[AW-1:0]),
    .wdata_i (element_value_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mme_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (signed'(rdata_a)),
    .b_i    (signed'(rdata_b)),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(8);
      cols_a_q <= DIM_W'(8);
      rows_b_q <= DIM_W'(8);
      cols_b_q <= DIM_W'(8);
    end else if (cfg_we_i) begin
      unique case (mme_reg_e'(cfg_index_i))
        REG_ROWS_A: rows_a_q <= cfg_data_i;
        REG_COLS_A: cols_a_q <= cfg_data_i;
        REG_ROWS_B: rows_b_q <= cfg_data_i;
        REG_COLS_B: cols_b_q <= cfg_data_i;
        default:    rows_a_q <= rows_a_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
      prod_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load_a) begin
            cnt_a_q <= (nxt_a >= size_a) ? '0 : nxt_a;
          end
          if (load_b) begin
            cnt_b_q <= b_full ? '0 : nxt_b;
            if (b_full) begin
              i_q     <= '0;
              j_q     <= '0;
              k_q     <= '0;
              state_q <= (ca != rb) ? S_ERR : S_MAC;
            end
          end
        end
        S_MAC: begin
          if (k_end) begin
            k_q     <= '0;
            state_q <= S_WAIT;
          end else begin
            k_q <= k_q + DW'(1);
          end
        end
        S_WAIT: begin
          if (mac_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            prod_q      <= acc;
            row_q       <= POS_W'(i_q);
            col_q       <= POS_W'(j_q);
            last_q      <= row_end && col_end;
            err_q       <= 1'b0;
            if (col_end) begin
              j_q <= '0;
              i_q <= i_q + DW'(1);
            end else begin
              j_q <= j_q + DW'(1);
            end
            state_q <= (row_end && col_end) ? S_IDLE : S_MAC;
          end
        end
        S_ERR: begin
          if (out_free) begin
            prod_q      <= '0;
            row_q       <= '0;
            col_q       <= '0;
            last_q      <= 1'b1;
            err_q       <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = prod_q;
  assign out_row_o       = row_q;
  assign out_col_o       = col_q;
  assign last_result_o   = last_q;
  assign size_error_o    = err_q;

  `MME_ASSERT_NEXT(a_mismatch_to_err, load_b && b_full && (ca != rb), state_q == S_ERR, "size mismatch did not raise error")
  `MME_ASSERT_NOW(a_done_in_wait, mac_done, state_q == S_WAIT, "accumulator finished outside wait")
  `MME_ASSERT_NOW(a_err_word_shape, out_valid_o && size_error_o, last_result_o && (product_value_o == '0), "malformed error word")
  `MME_ASSERT_NOW(a_no_load_while_busy, state_q != S_IDLE, !load_a && !load_b, "store written during product")

endmodule

// File: hdl/mme_mem.sv
// Element store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module mme_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned W     = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mme_mac.sv
// Multiply-accumulate pipeline: align with store read, multiply, accumulate.
// Depends on mme_pkg.
module mme_mac
  import mme_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mme_mac_ctl_t             ctl_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  output logic signed [PROD_W-1:0] acc_o,
  output logic                     done_o
);

  mme_mac_ctl_t             rd_ctl_q, mul_ctl_q;
  logic                     done_q;
  logic signed [MUL_W-1:0]  mul_q;
  logic signed [PROD_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q  <= '0;
      mul_ctl_q <= '0;
      done_q    <= 1'b0;
    end else begin
      rd_ctl_q  <= ctl_i;
      mul_ctl_q <= rd_ctl_q;
      done_q    <= mul_ctl_q.valid && mul_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_ctl_q.valid) begin
      mul_q <= a_i * b_i;
    end
    if (mul_ctl_q.valid) begin
      acc_q <= (mul_ctl_q.first ? '0 : acc_q) + PROD_W'(mul_q);
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// File: verif/matrix_multiply_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_engine: a table of directed words, then
// random load phases under three idle regimes, each result checked by table or predictor.
// Depends on mme_pkg and the engine RTL.
module matrix_multiply_engine_test;
  import mme_pkg::*;

  localparam int ITEMS          = 270;
  localparam int NUM_STEPS      = 33;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 64;

  typedef struct {
    logic signed [PROD_W-1:0] value;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
    logic                     err;
  } gemm_res_t;

  typedef enum logic {ROW_DIMS, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic                     op;
    logic [ELEM_W-1:0]        val;
    logic [15:0]              dims;
    bit                       typed;
    logic signed [PROD_W-1:0] tval;
    logic                     terr;
  } step_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [1:0]               cfg_index_i = REG_ROWS_A;
  logic [DIM_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     operation_i = OP_LOAD_A;
  logic signed [ELEM_W-1:0] element_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [PROD_W-1:0] product_value_o;
  logic [POS_W-1:0]         out_row_o;
  logic [POS_W-1:0]         out_col_o;
  logic                     last_result_o;
  logic                     size_error_o;

  matrix_multiply_engine DUT (.*);

  logic signed [ELEM_W-1:0] a_mem [64];
  logic signed [ELEM_W-1:0] b_mem [64];
  logic [63:0]              a_seen = '0;
  logic [DIM_W-1:0]         dim_ra = 4'd8, dim_ca = 4'd8, dim_rb = 4'd8, dim_cb = 4'd8;
  int unsigned              a_pos = 0, b_pos = 0;

  gemm_res_t product_due [$];
  gemm_res_t fresh [$];
  gemm_res_t due_head;
  gemm_res_t no_res;

  int          failures = 0;
  int          results_seen = 0;
  int          error_results = 0;
  int          words_sent = 0;
  int          phases = 0;
  int          idle_cycles = 0;
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 72;

  step_t plan [NUM_STEPS] = '{
    '{ROW_DIMS, OP_LOAD_A, 16'h0000, 16'h1111, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h7FFF, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h7FFF, 16'h0000, 1'b1, 35'sd1073676289, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h8000, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h8000, 16'h0000, 1'b1, 35'sd1073741824, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h7FFF, 16'h0000, 1'b1, -35'sd1073709056, 1'b0},
    '{ROW_DIMS, OP_LOAD_A, 16'h0000, 16'h2322, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h0000, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'hFFFF, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h0001, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h5555, 16'h0000, 1'b1, 35'sd0, 1'b1},
    '{ROW_DIMS, OP_LOAD_A, 16'h0000, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h0100, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'hFF00, 16'h0000, 1'b1, -35'sd65536, 1'b0},
    '{ROW_DIMS, OP_LOAD_A, 16'h0000, 16'hF110, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h7FFF, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h8000, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'hFFFF, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h0001, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h0000, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h0100, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'hAAAA, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h5555, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h8000, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_DIMS, OP_LOAD_A, 16'h0000, 16'h2221, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h1234, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'hEDCB, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'h7FFF, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h8000, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'h7FFF, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_DIMS, OP_LOAD_A, 16'h0000, 16'h1111, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_A, 16'hFFFF, 16'h0000, 1'b0, 35'sd0, 1'b0},
    '{ROW_WORD, OP_LOAD_B, 16'hFFFF, 16'h0000, 1'b1, 35'sd1, 1'b0}
  };

  always #5 clk_i = ~clk_i;

  function automatic int unsigned dim_of(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > 4'd8) return 8;
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 4'd0;
    if (r < 12) return DIM_W'($urandom_range(9, 15));
    if (r < 22) return 4'd8;
    return DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    return ELEM_W'($urandom);
  endfunction

  // Advance the mirrored stores and counters by one word; products land in fresh.
  task automatic gemm_word(input logic op, input logic signed [ELEM_W-1:0] val);
    int unsigned ra, ca, rb, cb;
    longint      acc;
    gemm_res_t   r;
    begin
      ra = dim_of(dim_ra);
      ca = dim_of(dim_ca);
      rb = dim_of(dim_rb);
      cb = dim_of(dim_cb);
      fresh.delete();
      if (op == OP_LOAD_A) begin
        if (a_pos >= ra * ca) a_pos = 0;
        a_mem[a_pos] = val;
        a_seen[a_pos] = 1'b1;
        a_pos++;
        if (a_pos >= ra * ca) a_pos = 0;
      end else begin
        if (b_pos >= rb * cb) b_pos = 0;
        b_mem[b_pos] = val;
        b_pos++;
        if (b_pos >= rb * cb) begin
          b_pos = 0;
          if (ca != rb) begin
            r = '{value: '0, row: '0, col: '0, last: 1'b1, err: 1'b1};
            fresh.push_back(r);
          end else begin
            for (int unsigned i = 0; i < ra; i++) begin
              for (int unsigned j = 0; j < cb; j++) begin
                acc = 0;
                for (int unsigned k = 0; k < ca; k++) begin
                  acc += longint'(a_mem[i * ca + k]) * longint'(b_mem[k * cb + j]);
                end
                r.value = acc[PROD_W-1:0];
                r.row   = POS_W'(i);
                r.col   = POS_W'(j);
                r.last  = (i == ra - 1) && (j == cb - 1);
                r.err   = 1'b0;
                fresh.push_back(r);
              end
            end
          end
        end
      end
    end
  endtask

  task automatic send_word(input logic op, input logic [ELEM_W-1:0] val, input bit typed,
                           input gemm_res_t fixed);
    begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      @(negedge clk_i);
      in_valid_i      <= 1'b1;
      operation_i     <= op;
      element_value_i <= val;
      do @(posedge clk_i); while (in_stall_o);
      gemm_word(op, val);
      if (typed) begin
        product_due.push_back(fixed);
      end else begin
        foreach (fresh[n]) product_due.push_back(fresh[n]);
      end
      words_sent++;
    end
  endtask

  // Hold off the sender until every product is out and the engine has gone quiet.
  task automatic settle();
    begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      while (product_due.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] ra, ca, rb, cb);
    logic [DIM_W-1:0] v [4];
    mme_reg_e         slot [4];
    begin
      v    = '{ra, ca, rb, cb};
      slot = '{REG_ROWS_A, REG_COLS_A, REG_ROWS_B, REG_COLS_B};
      for (int r = 0; r < 4; r++) begin
        @(negedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_index_i <= slot[r];
        cfg_data_i  <= v[r];
      end
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      dim_ra = ra;
      dim_ca = ca;
      dim_rb = rb;
      dim_cb = cb;
    end
  endtask

  task automatic run_phase();
    logic [DIM_W-1:0] d [4];
    int unsigned      sa, sb, n_a, n_b;
    bit               a_full;
    begin
      if (phases == 0 || phases == 3 || $urandom_range(0, 9) < 7) begin
        do begin
          for (int r = 0; r < 4; r++) d[r] = pick_dim();
          if ($urandom_range(0, 9) < 8) d[2] = d[1];
        end while (dim_of(d[0]) * dim_of(d[1]) + dim_of(d[2]) * dim_of(d[3]) > 48);
        if (phases == 3) d = '{4'd15, 4'd1, 4'd1, 4'd8};
        settle();
        set_dims(d[0], d[1], d[2], d[3]);
      end
      phases++;
      sa = dim_of(dim_ra) * dim_of(dim_ca);
      sb = dim_of(dim_rb) * dim_of(dim_cb);
      a_full = 1'b1;
      for (int unsigned k = 0; k < sa; k++) a_full &= a_seen[k];
      n_a = sa;
      if (a_full && $urandom_range(0, 99) < 15) n_a = $urandom_range(0, sa - 1);
      repeat (n_a) send_word(OP_LOAD_A, pick_elem(), 1'b0, no_res);
      n_b = sb - ((b_pos >= sb) ? 0 : b_pos);
      while (n_b != 0) begin
        if ($urandom_range(0, 99) < 8) begin
          send_word(OP_LOAD_A, pick_elem(), 1'b0, no_res);
        end else begin
          send_word(OP_LOAD_B, pick_elem(), 1'b0, no_res);
          n_b--;
        end
      end
    end
  endtask

  function automatic void report(input string what, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    failures++;
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (size_error_o) error_results++;
      if (product_due.size() == 0) begin
        $display("%0t ns: result with none outstanding, expected nothing, got %0d at (%0d,%0d)",
                 $time, product_value_o, out_row_o, out_col_o);
        failures++;
      end else begin
        due_head = product_due.pop_front();
        if (product_value_o !== due_head.value)
          report("product_value", due_head.value, product_value_o);
        if (out_row_o !== due_head.row) report("out_row", due_head.row, out_row_o);
        if (out_col_o !== due_head.col) report("out_col", due_head.col, out_col_o);
        if (last_result_o !== due_head.last)
          report("last_result", due_head.last, last_result_o);
        if (size_error_o !== due_head.err) report("size_error", due_head.err, size_error_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("matrix_multiply_engine_test NOT OK");
      $finish;
    end
  end

  initial begin
    int dir_words;
    int rand_done;
    int rand_target;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_STEPS; p++) begin
      if (plan[p].kind == ROW_DIMS) begin
        settle();
        set_dims(plan[p].dims[15:12], plan[p].dims[11:8], plan[p].dims[7:4],
                 plan[p].dims[3:0]);
      end else begin
        due_head = '{value: plan[p].tval, row: '0, col: '0, last: 1'b1, err: plan[p].terr};
        send_word(plan[p].op, plan[p].val, plan[p].typed, due_head);
      end
    end

    dir_words = words_sent;
    rand_target = ITEMS - dir_words;
    rand_done = 0;
    while (words_sent < ITEMS) begin
      if (rand_done < rand_target / 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 72;
      end else if (rand_done < 2 * rand_target / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase();
      rand_done = words_sent - dir_words;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Loaded %0d words across %0d random phases plus the directed table;",
             words_sent, phases);
    $display("checked %0d product words, %0d of them size errors.", results_seen,
             error_results);
    if (failures == 0) begin
      $display("matrix_multiply_engine_test OK");
    end else begin
      $display("matrix_multiply_engine_test NOT OK");
    end
    $finish;
  end

endmodule
